[design/psa_pkg.sv]
// Shared types and constants for the priority scheduler with aging.
// No dependencies.
`timescale 1ns / 1ps

package psa_pkg;

    localparam int PRIO_W  = 8;
    localparam int AGE_W   = 8;
    localparam int REM_W   = 16;
    localparam int WAIT_W  = 16;
    localparam int ORD_W   = 16;
    localparam int PHASE_W = 8;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [KIND_W-1:0] K_ARRIVING = 3'd0;
    localparam logic [KIND_W-1:0] K_AGING    = 3'd1;
    localparam logic [KIND_W-1:0] K_RUNNING  = 3'd2;
    localparam logic [KIND_W-1:0] K_FINISHED = 3'd3;
    localparam logic [KIND_W-1:0] K_REJECTED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGING_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT     = 2'd2;

    localparam logic [0:0] REQ_ARRIVAL = 1'b0;
    localparam logic [0:0] REQ_TICK = 1'b1;

    // per-cycle command broadcast to every queue cell
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SORT,
        OP_ROTATE,
        OP_SHIFT,
        OP_WAIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic odd;
    } t_cell_cmd;

endpackage

[design/psa_cell.sv]
// One ready-queue slot of the scheduler chain.
// Depends on psa_pkg.
`timescale 1ns / 1ps

module psa_cell import psa_pkg::*; #(
    parameter  int DEPTH    = 16,
    parameter  int IDX      = 0,
    parameter  int PID_BITS = 8,
    localparam int FW       = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  t_cell_cmd           i_cmd,
    input  logic [FW-1:0]       i_fill,
    input  logic [ORD_W-1:0]    i_serial,
    // entry for load / rotate
    input  logic [PID_BITS-1:0] i_ins_pid,
    input  logic [PRIO_W-1:0]   i_ins_prio,
    input  logic [AGE_W-1:0]    i_ins_age,
    input  logic [REM_W-1:0]    i_ins_rem,
    input  logic [WAIT_W-1:0]   i_ins_wait,
    input  logic [ORD_W-1:0]    i_ins_ord,
    // right neighbor
    input  logic [PID_BITS-1:0] i_r_pid,
    input  logic [PRIO_W-1:0]   i_r_prio,
    input  logic [AGE_W-1:0]    i_r_age,
    input  logic [REM_W-1:0]    i_r_rem,
    input  logic [WAIT_W-1:0]   i_r_wait,
    input  logic [ORD_W-1:0]    i_r_ord,
    // left neighbor
    input  logic [PID_BITS-1:0] i_l_pid,
    input  logic [PRIO_W-1:0]   i_l_prio,
    input  logic [AGE_W-1:0]    i_l_age,
    input  logic [REM_W-1:0]    i_l_rem,
    input  logic [WAIT_W-1:0]   i_l_wait,
    input  logic [ORD_W-1:0]    i_l_ord,
    input  logic                i_l_swap,
    output logic [PID_BITS-1:0] o_pid,
    output logic [PRIO_W-1:0]   o_prio,
    output logic [AGE_W-1:0]    o_age,
    output logic [REM_W-1:0]    o_rem,
    output logic [WAIT_W-1:0]   o_wait,
    output logic [ORD_W-1:0]    o_ord,
    output logic                o_swap
);

    localparam logic [FW-1:0] MY_POS   = FW'(IDX);
    localparam logic [FW-1:0] NEXT_POS = FW'(IDX + 1);
    localparam logic          MY_ODD   = 1'(IDX % 2);

    logic [PID_BITS-1:0] r_pid,  n_pid;
    logic [PRIO_W-1:0]   r_prio, n_prio;
    logic [AGE_W-1:0]    r_age,  n_age;
    logic [REM_W-1:0]    r_rem,  n_rem;
    logic [WAIT_W-1:0]   r_wait, n_wait;
    logic [ORD_W-1:0]    r_ord,  n_ord;

    logic [ORD_W-1:0] dist_r, dist_me;
    logic             r_ahead, pair_r, swap_r;

    // right entry belongs in front: higher priority, or same and older
    assign dist_r  = i_serial - i_r_ord;
    assign dist_me = i_serial - r_ord;
    assign r_ahead = (i_r_prio > r_prio) || ((i_r_prio == r_prio) && (dist_r > dist_me));
    assign pair_r  = (i_cmd.op == OP_SORT) && (NEXT_POS < i_fill) && (MY_ODD == i_cmd.odd);
    assign swap_r  = pair_r && r_ahead;
    assign o_swap  = swap_r;

    always_comb begin
        n_pid  = r_pid;
        n_prio = r_prio;
        n_age  = r_age;
        n_rem  = r_rem;
        n_wait = r_wait;
        n_ord  = r_ord;
        case (i_cmd.op)
            OP_LOAD: begin
                if (i_fill == MY_POS) begin
                    n_pid = i_ins_pid; n_prio = i_ins_prio; n_age = i_ins_age;
                    n_rem = i_ins_rem; n_wait = i_ins_wait; n_ord = i_ins_ord;
                end
            end
            OP_SORT: begin
                if (swap_r) begin
                    n_pid = i_r_pid; n_prio = i_r_prio; n_age = i_r_age;
                    n_rem = i_r_rem; n_wait = i_r_wait; n_ord = i_r_ord;
                end else if (i_l_swap) begin
                    n_pid = i_l_pid; n_prio = i_l_prio; n_age = i_l_age;
                    n_rem = i_l_rem; n_wait = i_l_wait; n_ord = i_l_ord;
                end
            end
            OP_ROTATE: begin
                if (NEXT_POS < i_fill) begin
                    n_pid = i_r_pid; n_prio = i_r_prio; n_age = i_r_age;
                    n_rem = i_r_rem; n_wait = i_r_wait; n_ord = i_r_ord;
                end else if (NEXT_POS == i_fill) begin
                    n_pid = i_ins_pid; n_prio = i_ins_prio; n_age = i_ins_age;
                    n_rem = i_ins_rem; n_wait = i_ins_wait; n_ord = i_ins_ord;
                end
            end
            OP_SHIFT: begin
                if (NEXT_POS < i_fill) begin
                    n_pid = i_r_pid; n_prio = i_r_prio; n_age = i_r_age;
                    n_rem = i_r_rem; n_wait = i_r_wait; n_ord = i_r_ord;
                end
            end
            OP_WAIT: begin
                if ((MY_POS < i_fill) && (r_wait != '1)) begin
                    n_wait = r_wait + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pid  <= n_pid;
        r_prio <= n_prio;
        r_age  <= n_age;
        r_rem  <= n_rem;
        r_wait <= n_wait;
        r_ord  <= n_ord;
    end

    assign o_pid  = r_pid;
    assign o_prio = r_prio;
    assign o_age  = r_age;
    assign o_rem  = r_rem;
    assign o_wait = r_wait;
    assign o_ord  = r_ord;

endmodule

[design/priority_scheduler_with_aging.sv]
// Top level: non-preemptive task scheduler with FIFO or priority ready queue.
// Depends on psa_pkg and psa_cell.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_req_type i_pid i_priority_req i_burst_time
//  output    out        o_out_valid / i_out_stall o_event_time o_event_pid o_event_kind
//                                                 o_waited o_started o_last
//  config    in         i_cfg_we                  i_cfg_index i_cfg_data
//
//  One item at a time; o_in_stall is high from acceptance until the item's
//  queue update is complete and its last result is in the output register.
//  Arrival: a load, plus QUEUE_DEPTH sort passes in priority mode.
//  Tick: when an aging pass runs, each queued task is rotated through the
//  cell chain, then QUEUE_DEPTH odd-even transposition sort passes follow;
//  then the dispatch or run step, and a finish step when a task completes. Output stalls add cycles.
//  Reset (i_rst_n low, synchronous) empties the queue and clears time.

module priority_scheduler_with_aging import psa_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 16,
    parameter int PID_BITS    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [PID_BITS-1:0]   i_pid,
    input  logic [PRIO_W-1:0]     i_priority_req,
    input  logic [REM_W-1:0]      i_burst_time,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TIME_BITS-1:0]  o_event_time,
    output logic [PID_BITS-1:0]   o_event_pid,
    output logic [KIND_W-1:0]     o_event_kind,
    output logic [WAIT_W-1:0]     o_waited,
    output logic [TIME_BITS-1:0]  o_started,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0] FULL     = FW'(QUEUE_DEPTH);
    localparam logic [FW-1:0] LAST_PASS = FW'(QUEUE_DEPTH - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ARRIVE = 6'b000010,
        S_AGE    = 6'b000100,
        S_SORT   = 6'b001000,
        S_EXEC   = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic                r_mode;
    logic [PHASE_W-1:0]  r_period, r_limit;

    // latched request
    logic [PID_BITS-1:0] r_req_pid, n_req_pid;
    logic [PRIO_W-1:0]   r_req_prio, n_req_prio;
    logic [REM_W-1:0]    r_req_burst, n_req_burst;

    // scheduler state
    logic [FW-1:0]        r_fill, n_fill;
    logic [FW-1:0]        r_cnt, n_cnt;
    logic                 r_sort_tick, n_sort_tick;
    logic [ORD_W-1:0]     r_serial, n_serial;
    logic                 r_busy, n_busy;
    logic [PID_BITS-1:0]  r_run_pid, n_run_pid;
    logic [REM_W-1:0]     r_run_rem, n_run_rem;
    logic [WAIT_W-1:0]    r_run_wait, n_run_wait;
    logic [TIME_BITS-1:0] r_run_start, n_run_start;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [PHASE_W-1:0]   r_phase, n_phase;

    // output register
    logic                 r_out_valid;
    logic [PID_BITS-1:0]  r_out_pid;
    logic [KIND_W-1:0]    r_out_kind;
    logic [WAIT_W-1:0]    r_out_waited;
    logic [TIME_BITS-1:0] r_out_time, r_out_started;
    logic                 r_out_last;

    logic                 can_emit, emit, e_last;
    logic [PID_BITS-1:0]  e_pid;
    logic [KIND_W-1:0]    e_kind;
    logic [WAIT_W-1:0]    e_waited;
    logic [TIME_BITS-1:0] e_started;

    t_cell_cmd cmd;

    // cell chain
    logic [PID_BITS-1:0] c_pid  [QUEUE_DEPTH];
    logic [PRIO_W-1:0]   c_prio [QUEUE_DEPTH];
    logic [AGE_W-1:0]    c_age  [QUEUE_DEPTH];
    logic [REM_W-1:0]    c_rem  [QUEUE_DEPTH];
    logic [WAIT_W-1:0]   c_wait [QUEUE_DEPTH];
    logic [ORD_W-1:0]    c_ord  [QUEUE_DEPTH];
    logic                c_swap [QUEUE_DEPTH];

    // entry fed to the chain: new task on arrival, aged head on rotation
    logic [PID_BITS-1:0] ins_pid;
    logic [PRIO_W-1:0]   ins_prio;
    logic [AGE_W-1:0]    ins_age;
    logic [REM_W-1:0]    ins_rem;
    logic [WAIT_W-1:0]   ins_wait;
    logic [ORD_W-1:0]    ins_ord;
    logic [AGE_W-1:0]    age_inc;
    logic                age_hit, due;
    logic [PHASE_W-1:0]  period_eff;

    assign age_inc = c_age[0] + 1'b1;
    assign age_hit = (age_inc >= r_limit);

    always_comb begin
        if (r_state == S_AGE) begin
            ins_pid  = c_pid[0];
            ins_prio = (age_hit && (c_prio[0] != '1)) ? c_prio[0] + 1'b1 : c_prio[0];
            ins_age  = age_hit ? '0 : age_inc;
            ins_rem  = c_rem[0];
            ins_wait = c_wait[0];
            ins_ord  = c_ord[0];
        end else begin
            ins_pid  = r_req_pid;
            ins_prio = r_req_prio;
            ins_age  = '0;
            ins_rem  = r_req_burst;
            ins_wait = '0;
            ins_ord  = r_serial;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            localparam int RI = (gi + 1 < QUEUE_DEPTH) ? gi + 1 : gi;
            localparam int LI = (gi > 0) ? gi - 1 : gi;
            psa_cell #(
                .DEPTH    (QUEUE_DEPTH),
                .IDX      (gi),
                .PID_BITS (PID_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_cmd      (cmd),
                .i_fill     (r_fill),
                .i_serial   (r_serial),
                .i_ins_pid  (ins_pid),
                .i_ins_prio (ins_prio),
                .i_ins_age  (ins_age),
                .i_ins_rem  (ins_rem),
                .i_ins_wait (ins_wait),
                .i_ins_ord  (ins_ord),
                .i_r_pid    (c_pid[RI]),
                .i_r_prio   (c_prio[RI]),
                .i_r_age    (c_age[RI]),
                .i_r_rem    (c_rem[RI]),
                .i_r_wait   (c_wait[RI]),
                .i_r_ord    (c_ord[RI]),
                .i_l_pid    (c_pid[LI]),
                .i_l_prio   (c_prio[LI]),
                .i_l_age    (c_age[LI]),
                .i_l_rem    (c_rem[LI]),
                .i_l_wait   (c_wait[LI]),
                .i_l_ord    (c_ord[LI]),
                .i_l_swap   ((gi > 0) ? c_swap[LI] : 1'b0),
                .o_pid      (c_pid[gi]),
                .o_prio     (c_prio[gi]),
                .o_age      (c_age[gi]),
                .o_rem      (c_rem[gi]),
                .o_wait     (c_wait[gi]),
                .o_ord      (c_ord[gi]),
                .o_swap     (c_swap[gi])
            );
        end
    endgenerate

    assign can_emit   = !r_out_valid || !i_out_stall;
    assign period_eff = (r_period == '0) ? PHASE_W'(1) : r_period;
    assign due        = (r_phase >= period_eff);

    always_comb begin
        n_state     = r_state;
        n_req_pid   = r_req_pid;
        n_req_prio  = r_req_prio;
        n_req_burst = r_req_burst;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_sort_tick = r_sort_tick;
        n_serial    = r_serial;
        n_busy      = r_busy;
        n_run_pid   = r_run_pid;
        n_run_rem   = r_run_rem;
        n_run_wait  = r_run_wait;
        n_run_start = r_run_start;
        n_time      = r_time;
        n_phase     = r_phase;
        cmd.op      = OP_HOLD;
        cmd.odd     = r_cnt[0];
        emit        = 1'b0;
        e_pid       = r_req_pid;
        e_kind      = K_ARRIVING;
        e_waited    = '0;
        e_started   = '0;
        e_last      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req_pid   = i_pid;
                    n_req_prio  = i_priority_req;
                    n_req_burst = i_burst_time;
                    if (i_req_type == REQ_ARRIVAL) begin
                        n_state = S_ARRIVE;
                    end else begin
                        // aging counter clears on a due pass, then counts this tick
                        if (due) begin
                            n_phase = PHASE_W'(1);
                        end else if (r_phase != '1) begin
                            n_phase = r_phase + 1'b1;
                        end
                        n_cnt = '0;
                        if (due && r_mode && (r_fill != '0)) begin
                            n_state = S_AGE;
                        end else begin
                            n_state = S_EXEC;
                        end
                    end
                end
            end
            S_ARRIVE: begin
                if (can_emit) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    if (r_fill == FULL) begin
                        e_kind  = K_REJECTED;
                        n_state = S_IDLE;
                    end else begin
                        cmd.op      = OP_LOAD;
                        n_serial    = r_serial + 1'b1;
                        n_fill      = r_fill + 1'b1;
                        n_cnt       = '0;
                        n_sort_tick = 1'b0;
                        n_state     = r_mode ? S_SORT : S_IDLE;
                    end
                end
            end
            S_AGE: begin
                // head reports and is re-inserted at the tail, aged
                if (can_emit) begin
                    emit   = 1'b1;
                    e_pid  = c_pid[0];
                    e_kind = K_AGING;
                    cmd.op = OP_ROTATE;
                    n_cnt  = r_cnt + 1'b1;
                    if (r_cnt == r_fill - 1'b1) begin
                        n_cnt       = '0;
                        n_sort_tick = 1'b1;
                        n_state     = S_SORT;
                    end
                end
            end
            S_SORT: begin
                cmd.op = OP_SORT;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_PASS) begin
                    n_state = r_sort_tick ? S_EXEC : S_IDLE;
                end
            end
            S_EXEC: begin
                if (r_busy) begin
                    if (can_emit) begin
                        emit      = 1'b1;
                        e_pid     = r_run_pid;
                        e_kind    = K_RUNNING;
                        e_last    = (r_run_rem != REM_W'(1));
                        cmd.op    = OP_WAIT;
                        n_run_rem = r_run_rem - 1'b1;
                        if (r_run_rem == REM_W'(1)) begin
                            n_state = S_FIN;
                        end else begin
                            n_time  = r_time + 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                end else if (r_fill != '0) begin
                    if (can_emit) begin
                        emit        = 1'b1;
                        e_pid       = c_pid[0];
                        e_kind      = K_RUNNING;
                        e_last      = (c_rem[0] != '0);
                        cmd.op      = OP_SHIFT;
                        n_fill      = r_fill - 1'b1;
                        n_busy      = 1'b1;
                        n_run_pid   = c_pid[0];
                        n_run_rem   = c_rem[0];
                        n_run_wait  = c_wait[0];
                        n_run_start = r_time;
                        if (c_rem[0] == '0) begin
                            n_state = S_FIN;
                        end else begin
                            n_time  = r_time + 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    // idle tick, nothing to report
                    n_time  = r_time + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    e_pid     = r_run_pid;
                    e_kind    = K_FINISHED;
                    e_waited  = r_run_wait;
                    e_started = r_run_start;
                    e_last    = 1'b1;
                    n_busy    = 1'b0;
                    n_time    = r_time + 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_period    <= PHASE_W'(8);
            r_limit     <= PHASE_W'(8);
            r_fill      <= '0;
            r_cnt       <= '0;
            r_sort_tick <= 1'b0;
            r_serial    <= '0;
            r_busy      <= 1'b0;
            r_run_pid   <= '0;
            r_run_rem   <= '0;
            r_run_wait  <= '0;
            r_run_start <= '0;
            r_time      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_sort_tick <= n_sort_tick;
            r_serial    <= n_serial;
            r_busy      <= n_busy;
            r_run_pid   <= n_run_pid;
            r_run_rem   <= n_run_rem;
            r_run_wait  <= n_run_wait;
            r_run_start <= n_run_start;
            r_time      <= n_time;
            r_phase     <= n_phase;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PRIORITY_MODE: r_mode   <= i_cfg_data[0];
                    REG_AGING_PERIOD:  r_period <= i_cfg_data;
                    REG_AGE_LIMIT:     r_limit  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request latch and output payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_req_pid   <= n_req_pid;
        r_req_prio  <= n_req_prio;
        r_req_burst <= n_req_burst;
        if (emit) begin
            r_out_time    <= r_time;
            r_out_pid     <= e_pid;
            r_out_kind    <= e_kind;
            r_out_waited  <= e_waited;
            r_out_started <= e_started;
            r_out_last    <= e_last;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_event_time = r_out_time;
    assign o_event_pid  = r_out_pid;
    assign o_event_kind = r_out_kind;
    assign o_waited     = r_out_waited;
    assign o_started    = r_out_started;
    assign o_last       = r_out_last;

endmodule

[tb/psa_checker.sv]
// Checker for the priority scheduler: watches both channels and the register port,
// predicts the event stream and compares it field by field. Depends on psa_pkg.
`timescale 1ns / 1ps

module psa_checker import psa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_req_type,
    input  logic [7:0]            i_pid,
    input  logic [PRIO_W-1:0]     i_priority_req,
    input  logic [REM_W-1:0]      i_burst_time,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [15:0]           i_event_time,
    input  logic [7:0]            i_event_pid,
    input  logic [KIND_W-1:0]     i_event_kind,
    input  logic [WAIT_W-1:0]     i_waited,
    input  logic [15:0]           i_started,
    input  logic                  i_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int DEPTH = 16;

    typedef struct {
        logic [7:0]  pid;
        logic [7:0]  prio;
        logic [7:0]  age;
        logic [15:0] remaining;
        logic [15:0] waiting;
        logic [15:0] serial;
    } queued_task_t;

    typedef struct {
        logic [15:0]       etime;
        logic [7:0]        pid;
        logic [KIND_W-1:0] kind;
        logic [15:0]       waited;
        logic [15:0]       started;
        logic              last;
    } sched_event_t;

    queued_task_t ready_q[DEPTH];
    sched_event_t expected_events[$];
    int           fill;
    logic [15:0]  enq_serial, now, run_left, run_waited, run_started;
    logic [7:0]   run_pid, phase;
    logic         busy;
    logic         prio_mode;
    logic [7:0]   aging_period, age_limit;

    assign o_pending = expected_events.size();

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic bit goes_first(queued_task_t a, queued_task_t b);
        logic [15:0] da, db;
        if (a.prio != b.prio) return a.prio > b.prio;
        da = enq_serial - a.serial;
        db = enq_serial - b.serial;
        return da > db;
    endfunction

    function automatic void reorder();
        queued_task_t t;
        for (int i = 1; i < fill; i++)
            for (int j = i; j > 0 && goes_first(ready_q[j], ready_q[j-1]); j--) begin
                t = ready_q[j];
                ready_q[j] = ready_q[j-1];
                ready_q[j-1] = t;
            end
    endfunction

    function automatic void emit(logic [7:0] pid, logic [KIND_W-1:0] kind,
                                 logic [15:0] w, logic [15:0] s);
        sched_event_t e;
        e.etime = now; e.pid = pid; e.kind = kind;
        e.waited = w; e.started = s; e.last = 1'b0;
        expected_events.push_back(e);
    endfunction

    // one accepted item -> expected events, last flag on the final one
    function automatic void schedule_step(logic rt, logic [7:0] pid, logic [7:0] pr,
                                          logic [15:0] bt);
        int n;
        sched_event_t e;
        n = 0;
        if (rt == REQ_ARRIVAL) begin
            if (fill >= DEPTH) begin
                emit(pid, K_REJECTED, 0, 0);
            end else begin
                ready_q[fill] = '{pid, pr, 8'd0, bt, 16'd0, enq_serial};
                enq_serial++;
                fill++;
                if (prio_mode) reorder();
                emit(pid, K_ARRIVING, 0, 0);
            end
            n = 1;
        end else begin
            if (phase >= ((aging_period == 0) ? 8'd1 : aging_period)) begin
                phase = 0;
                if (prio_mode) begin
                    for (int i = 0; i < fill; i++) begin
                        emit(ready_q[i].pid, K_AGING, 0, 0);
                        n++;
                    end
                    for (int i = 0; i < fill; i++) begin
                        ready_q[i].age++;
                        if (ready_q[i].age >= age_limit) begin
                            if (ready_q[i].prio != 8'hFF) ready_q[i].prio++;
                            ready_q[i].age = 0;
                        end
                    end
                    reorder();
                end
            end
            if (!busy) begin
                if (fill > 0) begin
                    run_pid = ready_q[0].pid;
                    run_left = ready_q[0].remaining;
                    run_waited = ready_q[0].waiting;
                    run_started = now;
                    for (int i = 1; i < fill; i++) ready_q[i-1] = ready_q[i];
                    fill--;
                    busy = 1'b1;
                    emit(run_pid, K_RUNNING, 0, 0);
                    n++;
                end
            end else begin
                if (run_left > 0) run_left--;
                emit(run_pid, K_RUNNING, 0, 0);
                n++;
                for (int i = 0; i < fill; i++)
                    if (ready_q[i].waiting != 16'hFFFF) ready_q[i].waiting++;
            end
            if (busy && run_left == 0) begin
                emit(run_pid, K_FINISHED, run_waited, run_started);
                n++;
                busy = 1'b0;
            end
            if (phase != 8'hFF) phase++;
            now++;
        end
        if (n > 0) begin
            e = expected_events.pop_back();
            e.last = 1'b1;
            expected_events.push_back(e);
        end
    endfunction

    initial o_errors = 0;

    always @(posedge i_clk) begin
        sched_event_t e;
        if (!i_rst_n) begin
            fill = 0; enq_serial = 0; busy = 0; run_pid = 0; run_left = 0;
            run_waited = 0; run_started = 0; now = 0; phase = 0;
            prio_mode = 0; aging_period = 8; age_limit = 8;
            expected_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PRIORITY_MODE: prio_mode = i_cfg_data[0];
                    REG_AGING_PERIOD:  aging_period = i_cfg_data;
                    REG_AGE_LIMIT:     age_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    report("unexpected item, pid", i_event_pid, 0);
                end else begin
                    e = expected_events.pop_front();
                    if (i_event_time !== e.etime) report("event_time", i_event_time, e.etime);
                    if (i_event_pid !== e.pid)    report("event_pid", i_event_pid, e.pid);
                    if (i_event_kind !== e.kind)  report("event_kind", i_event_kind, e.kind);
                    if (i_waited !== e.waited)    report("waited", i_waited, e.waited);
                    if (i_started !== e.started)  report("started", i_started, e.started);
                    if (i_last !== e.last)        report("last", i_last, e.last);
                end
            end
            if (i_in_valid && !i_in_stall)
                schedule_step(i_req_type, i_pid, i_priority_req, i_burst_time);
        end
    end

endmodule

[tb/tb_priority_scheduler_with_aging.sv]
// Testbench top for priority_scheduler_with_aging: clock, reset, stimulus, verdict.
// Depends on psa_pkg, the DUT and psa_checker.
`timescale 1ns / 1ps

module tb_priority_scheduler_with_aging;
    import psa_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_req_type = 1'b0;
    logic [7:0]            i_pid = '0;
    logic [PRIO_W-1:0]     i_priority_req = '0;
    logic [REM_W-1:0]      i_burst_time = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [15:0]           o_event_time;
    logic [7:0]            o_event_pid;
    logic [KIND_W-1:0]     o_event_kind;
    logic [WAIT_W-1:0]     o_waited;
    logic [15:0]           o_started;
    logic                  o_last;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors, pending;
    int send_idle_pct = 0;  // chance per cycle that the sender holds off
    int recv_idle_pct = 0;  // chance per cycle that the receiver stalls

    always #1 i_clk = ~i_clk;

    priority_scheduler_with_aging DUT (.*);

    psa_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_in_stall(o_in_stall),
        .i_req_type, .i_pid, .i_priority_req, .i_burst_time,
        .i_out_valid(o_out_valid),
        .i_out_stall,
        .i_event_time(o_event_time), .i_event_pid(o_event_pid),
        .i_event_kind(o_event_kind), .i_waited(o_waited),
        .i_started(o_started), .i_last(o_last),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(input logic rt, input logic [7:0] pid,
                             input logic [7:0] pr, input logic [15:0] bt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_req_type = rt;
        i_pid = pid;
        i_priority_req = pr;
        i_burst_time = bt;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // all results in, then room for an idle tick still in flight
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: shortest aging period and limit so a full queue ages at once
        write_reg(REG_PRIORITY_MODE, 8'd1);
        write_reg(REG_AGING_PERIOD, 8'd1);
        write_reg(REG_AGE_LIMIT, 8'd1);
        // zero burst finishes on its dispatch tick
        send_item(REQ_ARRIVAL, 8'h00, 8'h00, 16'h0000);
        send_item(REQ_TICK, 8'h00, 8'h00, 16'h0000);
        // fill the queue; priority ties and the saturating top priority
        for (int i = 0; i < 16; i++)
            send_item(REQ_ARRIVAL, (i % 2) ? 8'hFF : 8'(i),
                      (i < 4) ? 8'hFF : ((i % 3 == 0) ? 8'h00 : 8'h55),
                      16'($urandom_range(1, 2)));
        // full queue: rejected, payload bits exercised
        send_item(REQ_ARRIVAL, 8'hA5, 8'hFF, 16'hFFFF);
        send_item(REQ_ARRIVAL, 8'h5A, 8'h00, 16'h0000);
        // aging over a full queue plus running and finished
        repeat (3) send_item(REQ_TICK, 8'h00, 8'h00, 16'h0000);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 18; recv_idle_pct = 70;
                    write_reg(REG_PRIORITY_MODE, 8'd0);
                    write_reg(REG_AGING_PERIOD, 8'd8);
                    write_reg(REG_AGE_LIMIT, 8'd8);
                end
                1: begin
                    send_idle_pct = 70; recv_idle_pct = 18;
                    write_reg(REG_PRIORITY_MODE, 8'd1);
                    write_reg(REG_AGING_PERIOD, 8'd255);
                    write_reg(REG_AGE_LIMIT, 8'd255);
                end
                default: begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                    write_reg(REG_AGING_PERIOD, 8'd3);
                    write_reg(REG_AGE_LIMIT, 8'd2);
                end
            endcase
            // one arrival in four with short bursts keeps the queue near balance
            for (int n = 0; n < 96; n++) begin
                if ($urandom_range(3) == 0)
                    send_item(REQ_ARRIVAL, 8'($urandom), 8'($urandom),
                              16'($urandom_range(1, 3)));
                else
                    send_item(REQ_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
            end
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
